// ===== sv/msa_pkg.sv =====
// Shared constants and status types for the moving-average smoother.
package msa_pkg;

    localparam int WL_BITS          = 7;   // window_length register width
    localparam int DEF_MAX_WINDOW   = 64;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int QUEUE_DEPTH      = 2;   // front-to-back sample queue

    // divider status as seen by the back end
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // back-end status as seen by the top level
    typedef struct packed {
        logic busy;
        logic drop;
    } t_back_stat;

endpackage

// ===== sv/msa_front.sv =====
// Front end: accepts samples and holds them in a short queue for the back end.
module msa_front #(
    parameter int SAMPLE_BITS = msa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_q_valid,
    output logic signed [SAMPLE_BITS-1:0] o_q_sample,
    input  logic                          i_q_pop
);
    import msa_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic signed [SAMPLE_BITS-1:0] r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic          push;

    assign o_sample_ready = (r_cnt < NW'(QUEUE_DEPTH));
    assign push           = i_sample_valid && o_sample_ready;
    assign o_q_valid      = (r_cnt != '0);
    assign o_q_sample     = r_q[r_rp];

    function automatic logic [PW-1:0] f_wrap(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= f_wrap(r_wp);
            end
            if (i_q_pop) begin
                r_rp <= f_wrap(r_rp);
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/msa_div.sv =====
// Iterative signed divider: one quotient bit per cycle, truncates toward zero.
module msa_div #(
    parameter int TW = 23,
    parameter int CW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [TW-1:0] i_dividend,
    input  logic [CW-1:0]        i_divisor,
    output logic [TW-1:0]        o_quotient,
    output msa_pkg::t_div_stat   o_stat
);
    import msa_pkg::*;

    localparam int SW = $clog2(TW + 1);

    logic [TW-1:0] r_quo;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_div;
    logic          r_neg;
    logic [SW-1:0] r_step;
    logic          r_busy;
    logic          r_done;

    logic [CW:0]   shifted;
    logic [CW:0]   diff;
    logic [TW-1:0] mag;

    assign mag     = i_dividend[TW-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign shifted = {r_rem, r_quo[TW-1]};
    assign diff    = shifted - {1'b0, r_div};

    assign o_quotient  = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_quo  <= mag;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_neg  <= i_dividend[TW-1];
            r_step <= SW'(TW);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (!diff[CW]) begin
                r_rem <= diff[CW-1:0];
                r_quo <= {r_quo[TW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[CW-1:0];
                r_quo <= {r_quo[TW-2:0], 1'b0};
            end
            r_step <= r_step - 1'b1;
            if (r_step == SW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

// ===== sv/msa_back.sv =====
// Back end: sample store, drops of old entries, running total, divide and result register.
module msa_back #(
    parameter int MAX_WINDOW  = msa_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = msa_pkg::DEF_SAMPLE_BITS,
    parameter int CW          = $clog2(MAX_WINDOW + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_q_sample,
    output logic                          o_q_pop,
    input  logic [CW-1:0]                 i_window,
    output logic                          o_average_valid,
    input  logic                          i_average_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    output logic [CW-1:0]                 o_held_count,
    output msa_pkg::t_back_stat           o_stat
);
    import msa_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int TW = SAMPLE_BITS + CW;
    localparam int OW = CW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DROP,
        S_WRITE,
        S_START,
        S_DIV
    } t_state;

    t_state                        r_state;
    logic [AW-1:0]                 r_slot;
    logic [CW-1:0]                 r_count;
    logic signed [TW-1:0]          r_total;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic [OW-1:0] oldest_sum;
    logic [AW-1:0] oldest;
    logic          rd_en;
    logic          wr_en;
    logic          div_start;
    logic          out_free;
    logic          out_load;
    logic [TW-1:0] quotient;
    t_div_stat     div_stat;

    msa_div #(
        .TW (TW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_total),
        .i_divisor  (r_count),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    // slot of the oldest held entry, modulo store depth
    assign oldest_sum = OW'(r_slot) + OW'(MAX_WINDOW) - OW'(r_count);
    assign oldest     = (oldest_sum >= OW'(MAX_WINDOW)) ?
                        AW'(oldest_sum - OW'(MAX_WINDOW)) : AW'(oldest_sum);

    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign rd_en     = (r_state == S_CHECK) && (r_count >= i_window);
    assign wr_en     = (r_state == S_WRITE);
    assign div_start = (r_state == S_START);
    assign out_free  = !r_out_valid || i_average_ready;
    assign out_load  = (r_state == S_DIV) && div_stat.done && out_free;

    assign o_average_valid = r_out_valid;
    assign o_average       = r_out;
    assign o_held_count    = r_count;
    assign o_stat.busy     = (r_state != S_IDLE);
    assign o_stat.drop     = (r_state == S_DROP);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_slot] <= r_sample;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[oldest];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_average_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_sample <= i_q_sample;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= rd_en ? S_DROP : S_WRITE;
                end
                S_DROP: begin
                    r_total <= r_total - TW'(r_rd_data);
                    r_count <= r_count - 1'b1;
                    r_state <= S_CHECK;
                end
                S_WRITE: begin
                    r_total <= r_total + TW'(r_sample);
                    r_count <= r_count + 1'b1;
                    r_slot  <= (r_slot == AW'(MAX_WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (out_load) begin
                        r_out   <= quotient[SAMPLE_BITS-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/moving_average_smoother_top.sv =====
// Top level of the boxcar moving-average smoother: window register, front queue, back end.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-----------------------------------
//  sample   | i_sample_valid / o_sample_ready  | i_sample        (signed Q7.8)
//  average  | o_average_valid / i_average_ready| o_average       (signed Q7.8)
//  config   | i_cfg_valid / o_cfg_ready        | i_window_length (7 bit, unsigned)
//
// With the back end idle, a sample transfer passes through the check, write, start and
// divide states before o_average_valid rises, the divider giving one quotient bit per
// cycle; each held entry dropped adds a store read in check and a subtract in drop.
// A full window drops one entry per item.
// Reset is synchronous, active low; store contents are not cleared, only the back end's
// count, slot, total, state and output valid flag, so no clearing pass is needed.
// A two-entry queue takes samples while the back end works; a result waiting in
// the output register stalls the back end, and the sample input once the queue is full.
module moving_average_smoother_top #(
    parameter int MAX_WINDOW  = msa_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = msa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_average_valid,
    input  logic                          i_average_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [msa_pkg::WL_BITS-1:0]   i_window_length
);
    import msa_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic [WL_BITS-1:0]            r_window_length;
    logic [CW-1:0]                 eff_window;
    logic                          q_valid;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic                          q_pop;
    logic [CW-1:0]                 held_count;
    t_back_stat                    back_stat;

    // config writes must arrive only while idle, unenforced; the register is always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WL_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_length <= i_window_length;
        end
    end

    // zero window acts as one; anything above store depth clamps to it
    always_comb begin
        if (r_window_length == '0) begin
            eff_window = CW'(1);
        end else if (int'(r_window_length) > MAX_WINDOW) begin
            eff_window = CW'(MAX_WINDOW);
        end else begin
            eff_window = CW'(r_window_length);
        end
    end

    msa_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_q_valid      (q_valid),
        .o_q_sample     (q_sample),
        .i_q_pop        (q_pop)
    );

    msa_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_sample      (q_sample),
        .o_q_pop         (q_pop),
        .i_window        (eff_window),
        .o_average_valid (o_average_valid),
        .i_average_ready (i_average_ready),
        .o_average       (o_average),
        .o_held_count    (held_count),
        .o_stat          (back_stat)
    );

`ifndef SYNTHESIS
    // the store never holds more entries than it has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held_count <= CW'(MAX_WINDOW))
        else $error("held count exceeds store depth");

    // a drop step only runs with at least one held entry
    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.drop |-> (held_count != '0))
        else $error("drop with empty store");

    // a pop from the queue starts work in the back end
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_valid) |=> back_stat.busy)
        else $error("back end idle after pop");

    // the back end only pops when it is idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_valid && !back_stat.busy))
        else $error("pop while busy or queue empty");
`endif

endmodule
